// ===== design/hdcpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdcpc_pkg
// Shared types, codes and fixed-point helpers of the projection classifier.
// ----------------------------------------------------------------------------
package hdcpc_pkg;

   // fixed field widths
   localparam int NF_MAX    = 5;
   localparam int CMD_W     = 3;
   localparam int FEAT_W    = 16;
   localparam int LABEL_W   = 4;
   localparam int ROW_W     = 10;
   localparam int COL_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int SCORE_W   = 26;
   localparam int STORED_W  = 7;
   localparam int TRAINED_W = 16;
   localparam int BYTE_W    = 8;

   // command codes on the wire
   localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TRAIN    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PREDICT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BINARIZE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RETRAIN  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_LABEL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd2;

   // dequantize: x / 255 as (x * DEQ_RECIP) >> DEQ_SHIFT, exact for x below 2^22
   localparam logic [23:0] DEQ_RECIP = 24'd8421505;
   localparam int          DEQ_SHIFT = 31;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_TRAIN,
      OP_PREDICT,
      OP_BINARIZE,
      OP_RETRAIN,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_PICK,
      ST_RT_CLEAR,
      ST_RT_READ,
      ST_RT_DEQ,
      ST_DONE
   } state_type;

   // one decoded word in the queue between front and back
   typedef struct packed {
      op_type                          op;
      logic [STATUS_W-1:0]             status;
      logic [NF_MAX-1:0][FEAT_W-1:0]   feature;
      logic [LABEL_W-1:0]              label;
      logic [ROW_W-1:0]                row;
      logic [COL_W-1:0]                col;
      logic [FEAT_W-1:0]               value;
   } cmd_word_type;

   // back-end feedback to the front end
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   // clamp to [-1, 1] in Q2.13 and map to a byte
   function automatic logic [BYTE_W-1:0] quantize(input logic signed [FEAT_W-1:0] c);
      logic [14:0] u;
      logic [22:0] t;
      logic signed [FEAT_W:0] s;
      s = FEAT_W'(c) + 17'sd8192;
      if (c < -16'sd8192) begin
         u = 15'd0;
      end else if (c > 16'sd8192) begin
         u = 15'd16384;
      end else begin
         u = s[14:0];
      end
      t = {u, 8'd0} - 23'(u);
      return t[21:14];
   endfunction

   // byte back to Q2.13, rounded half up
   function automatic logic signed [FEAT_W-1:0] dequantize(input logic [BYTE_W-1:0] r);
      logic [21:0] x;
      logic [45:0] p;
      logic [14:0] q;
      x = {r, 14'd0} + 22'd127;
      p = 46'(x) * 46'(DEQ_RECIP);
      q = p[DEQ_SHIFT+14:DEQ_SHIFT];
      return $signed({1'b0, q}) - 16'sd8192;
   endfunction

endpackage

// ===== design/hdcpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdcpc_front
// Accepts request words, checks and decodes them, and queues them for the back.
// ----------------------------------------------------------------------------
module hdcpc_front #(
   parameter int DIM          = 1024,
   parameter int NUM_FEATURES = 5,
   parameter int NUM_CLASSES  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hdcpc_pkg::CMD_W-1:0]       req_cmd,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_0,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_1,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_2,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_3,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_4,
   input  logic [hdcpc_pkg::LABEL_W-1:0]     req_label,
   input  logic [hdcpc_pkg::ROW_W-1:0]       req_proj_row,
   input  logic [hdcpc_pkg::COL_W-1:0]       req_proj_col,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_proj_value,
   input  hdcpc_pkg::back_status_type        back_status,
   output hdcpc_pkg::cmd_word_type           head_word,
   output logic                              head_valid
);
   import hdcpc_pkg::*;

   cmd_word_type word_in;
   cmd_word_type queue_ff [2];
   logic         wr_ff;
   logic         rd_ff;
   logic [1:0]   cnt_ff;
   logic         push;

   // decode the command and check its indexes
   always_comb begin
      word_in.feature = {req_feature_4, req_feature_3, req_feature_2,
                         req_feature_1, req_feature_0};
      word_in.label   = req_label;
      word_in.row     = req_proj_row;
      word_in.col     = req_proj_col;
      word_in.value   = req_proj_value;
      word_in.status  = STAT_OK;
      word_in.op      = OP_NONE;
      case (req_cmd)
         CMD_LOAD: begin
            if (32'(req_proj_row) >= DIM || 32'(req_proj_col) >= NUM_FEATURES) begin
               word_in.status = STAT_BAD_INDEX;
            end else begin
               word_in.op = OP_LOAD;
            end
         end
         CMD_TRAIN: begin
            if (32'(req_label) >= NUM_CLASSES) begin
               word_in.status = STAT_BAD_LABEL;
            end else begin
               word_in.op = OP_TRAIN;
            end
         end
         CMD_PREDICT:  word_in.op = OP_PREDICT;
         CMD_BINARIZE: word_in.op = OP_BINARIZE;
         CMD_RETRAIN:  word_in.op = OP_RETRAIN;
         default:      word_in.op = OP_NONE;
      endcase
   end

   // hold off while full or while the back clears its sums
   assign req_stall  = (cnt_ff == 2'd2) || back_status.clearing;
   assign push       = req_valid && !req_stall;
   assign head_word  = queue_ff[rd_ff];
   assign head_valid = (cnt_ff != 2'd0);

   // two-word queue
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ff] <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (back_status.pop) begin
            rd_ff <= !rd_ff;
         end
         if (push && !back_status.pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (!push && back_status.pop) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

// ===== design/hdcpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdcpc_back
// Executes queued words: sweeps the dimensions one per cycle through the
// projection and class sum memories, and keeps the sample ring.
// ----------------------------------------------------------------------------
module hdcpc_back #(
   parameter int DIM          = 1024,
   parameter int NUM_FEATURES = 5,
   parameter int NUM_CLASSES  = 4,
   parameter int RING_DEPTH   = 64,
   parameter int SUM_WIDTH    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hdcpc_pkg::cmd_word_type             head_word,
   input  logic                                head_valid,
   output hdcpc_pkg::back_status_type          back_status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hdcpc_pkg::LABEL_W-1:0]       rsp_class_index,
   output logic signed [hdcpc_pkg::SCORE_W-1:0] rsp_best_score,
   output logic [hdcpc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [hdcpc_pkg::STORED_W-1:0]      rsp_samples_stored,
   output logic [hdcpc_pkg::TRAINED_W-1:0]     rsp_trained_total
);
   import hdcpc_pkg::*;

   localparam int ADDR_W  = $clog2(DIM);
   localparam int AC_W    = ADDR_W + 1;
   localparam int RA_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int J_W     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   localparam int C_W     = $clog2(NUM_CLASSES);
   localparam int PROD_W  = 2 * FEAT_W;
   localparam int DOT_W   = PROD_W + 3;
   localparam int ACC_W   = SUM_WIDTH + ADDR_W + 1;
   localparam int CMP_W   = ((ACC_W > SCORE_W) ? ACC_W : SCORE_W) + 1;
   localparam int RING_W  = NUM_FEATURES * BYTE_W + LABEL_W;
   localparam logic signed [SUM_WIDTH:0] SUM_LIM =
      (SUM_WIDTH+1)'((64'd1 << (SUM_WIDTH - 1)) - 64'd1);
   localparam logic signed [CMP_W-1:0] SCORE_MAX = CMP_W'(33554431);
   localparam logic signed [CMP_W-1:0] SCORE_MIN = -CMP_W'(33554432);

   typedef logic [NUM_CLASSES-1:0][SUM_WIDTH-1:0] row_type;

   // memories
   logic [FEAT_W-1:0]  proj_mem [NUM_FEATURES][DIM];
   row_type            class_mem [DIM];
   logic [RING_W-1:0]  ring_mem [RING_DEPTH];

   state_type state_ff, state_in;
   op_type    mode_ff;
   logic      rt_ff;

   logic [AC_W-1:0]   a_ff;
   logic              v0;
   logic              v1_ff, v2_ff;
   logic [ADDR_W-1:0] a1_ff, a2_ff;
   logic signed [FEAT_W-1:0] proj_rd_ff [NUM_FEATURES];
   logic signed [FEAT_W-1:0] feat_ff [NUM_FEATURES];
   logic signed [PROD_W-1:0] prod_ff [NUM_FEATURES];
   logic signed [PROD_W-1:0] prod_in [NUM_FEATURES];
   row_type           cls_rd_ff, cls2_ff, row_in;
   logic signed [DOT_W-1:0] dot;
   logic              hv;

   logic [LABEL_W-1:0] label_ff;
   logic [STATUS_W-1:0] status_ff;
   logic signed [ACC_W-1:0] score_ff [NUM_CLASSES];
   logic signed [ACC_W-1:0] best_ff;
   logic [C_W-1:0]    pick_ff;
   logic [LABEL_W-1:0] cls_ff;

   logic [RA_W-1:0]   head_ff, rt_idx_ff, rt_idx_first;
   logic [CNT_W-1:0]  cnt_ff, rt_n_ff, rt_k_ff;
   logic [J_W-1:0]    j_ff;
   logic [RING_W-1:0] ring_rd_ff, ring_wr;
   logic [TRAINED_W-1:0] trained_ff;

   logic clear_last, sweep_last, rt_last, pick_last, deq_last;
   logic start_sweep, start_clear, rsp_load;
   logic pop, load_we, class_we;
   logic [ADDR_W-1:0] class_waddr;
   row_type           class_wdata;
   logic signed [CMP_W-1:0] best_ext, best_sat;
   logic rsp_valid_ff;
   logic [LABEL_W-1:0] rsp_cls_ff;
   logic signed [SCORE_W-1:0] rsp_best_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STORED_W-1:0] rsp_stored_ff;
   logic [TRAINED_W-1:0] rsp_trained_ff;

   assign v0         = (state_ff == ST_SWEEP) && (a_ff < AC_W'(DIM));
   assign clear_last = (a_ff == AC_W'(DIM - 1));
   assign sweep_last = v2_ff && (a2_ff == ADDR_W'(DIM - 1));
   assign rt_last    = (rt_k_ff + CNT_W'(1)) == rt_n_ff;
   assign pick_last  = (pick_ff == C_W'(NUM_CLASSES - 1));
   assign deq_last   = (j_ff == J_W'(NUM_FEATURES - 1));
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // next state and handshake to the front
   always_comb begin
      state_in    = state_ff;
      pop         = 1'b0;
      start_sweep = 1'b0;
      start_clear = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               case (head_word.op)
                  OP_TRAIN, OP_PREDICT, OP_BINARIZE: begin
                     state_in    = ST_SWEEP;
                     start_sweep = 1'b1;
                  end
                  OP_RETRAIN: begin
                     state_in    = ST_RT_CLEAR;
                     start_clear = 1'b1;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               case (mode_ff)
                  OP_TRAIN: begin
                     if (!rt_ff) begin
                        state_in = ST_DONE;
                     end else if (rt_last) begin
                        start_sweep = 1'b1;
                     end else begin
                        state_in = ST_RT_READ;
                     end
                  end
                  OP_PREDICT: state_in = ST_PICK;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_PICK: begin
            if (pick_last) state_in = ST_DONE;
         end
         ST_RT_CLEAR: begin
            if (clear_last) begin
               if (cnt_ff == '0) begin
                  state_in    = ST_SWEEP;
                  start_sweep = 1'b1;
               end else begin
                  state_in = ST_RT_READ;
               end
            end
         end
         ST_RT_READ: state_in = ST_RT_DEQ;
         ST_RT_DEQ: begin
            if (deq_last) begin
               state_in    = ST_SWEEP;
               start_sweep = 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign back_status.pop      = pop;
   assign back_status.clearing = (state_ff == ST_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // projection memories, one per feature column
   assign load_we = pop && (head_word.op == OP_LOAD);
   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_FEATURES; j++) begin
         if (load_we && head_word.col == COL_W'(j)) begin
            proj_mem[j][ADDR_W'(head_word.row)] <= head_word.value;
         end
         proj_rd_ff[j] <= proj_mem[j][a_ff[ADDR_W-1:0]];
      end
   end

   // products of the current dimension
   always_comb begin
      for (int j = 0; j < NUM_FEATURES; j++) begin
         prod_in[j] = proj_rd_ff[j] * feat_ff[j];
      end
   end

   // sign of the dot product and the updated class row
   always_comb begin
      logic signed [SUM_WIDTH:0] s;
      dot = '0;
      for (int j = 0; j < NUM_FEATURES; j++) begin
         dot = dot + DOT_W'(prod_ff[j]);
      end
      hv = !dot[DOT_W-1];
      row_in = cls2_ff;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         s = (SUM_WIDTH+1)'($signed(cls2_ff[c])) +
             (hv ? (SUM_WIDTH+1)'(1) : -(SUM_WIDTH+1)'(1));
         if (mode_ff == OP_BINARIZE) begin
            row_in[c] = cls2_ff[c][SUM_WIDTH-1] ? SUM_WIDTH'(-1) : SUM_WIDTH'(1);
         end else if (label_ff == LABEL_W'(c)) begin
            if (s > SUM_LIM) begin
               row_in[c] = SUM_LIM[SUM_WIDTH-1:0];
            end else if (s < -SUM_LIM) begin
               row_in[c] = SUM_WIDTH'(-SUM_LIM);
            end else begin
               row_in[c] = s[SUM_WIDTH-1:0];
            end
         end
      end
   end

   // class sum memory write port: clearing pass or sweep write-back
   always_comb begin
      class_we    = 1'b0;
      class_waddr = a2_ff;
      class_wdata = row_in;
      if (state_ff == ST_CLEAR || state_ff == ST_RT_CLEAR) begin
         class_we    = 1'b1;
         class_waddr = a_ff[ADDR_W-1:0];
         class_wdata = '0;
      end else if (v2_ff && (mode_ff == OP_TRAIN || mode_ff == OP_BINARIZE)) begin
         class_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (class_we) begin
         class_mem[class_waddr] <= class_wdata;
      end
      cls_rd_ff <= class_mem[a_ff[ADDR_W-1:0]];
   end

   // sample ring
   always_comb begin
      ring_wr = '0;
      ring_wr[RING_W-1 -: LABEL_W] = head_word.label;
      for (int j = 0; j < NUM_FEATURES; j++) begin
         ring_wr[j*BYTE_W +: BYTE_W] = quantize(head_word.feature[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_word.op == OP_TRAIN) begin
         ring_mem[head_ff] <= ring_wr;
      end
      ring_rd_ff <= ring_mem[rt_idx_ff];
   end

   // oldest ring slot
   always_comb begin
      logic [CNT_W:0] h;
      logic [CNT_W:0] n;
      logic [CNT_W:0] d;
      h = (CNT_W+1)'(head_ff);
      n = (CNT_W+1)'(cnt_ff);
      d = (h >= n) ? (h - n) : (h + (CNT_W+1)'(RING_DEPTH) - n);
      rt_idx_first = d[RA_W-1:0];
   end

   // pipeline registers of the sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v0;
         v2_ff <= v1_ff;
      end
      a1_ff   <= a_ff[ADDR_W-1:0];
      a2_ff   <= a1_ff;
      prod_ff <= prod_in;
      cls2_ff <= cls_rd_ff;
   end

   // sweep address and sequencer data
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff       <= '0;
         head_ff    <= '0;
         cnt_ff     <= '0;
         trained_ff <= '0;
         rt_ff      <= 1'b0;
      end else begin
         if (start_sweep || start_clear) begin
            a_ff <= '0;
         end else if (v0 || state_ff == ST_CLEAR || state_ff == ST_RT_CLEAR) begin
            a_ff <= a_ff + AC_W'(1);
         end
         if (pop && head_word.op == OP_TRAIN) begin
            head_ff <= (head_ff == RA_W'(RING_DEPTH - 1)) ? '0 : head_ff + RA_W'(1);
            if (cnt_ff != CNT_W'(RING_DEPTH)) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
         if (sweep_last && mode_ff == OP_TRAIN && trained_ff != '1) begin
            trained_ff <= trained_ff + TRAINED_W'(1);
         end
         if (pop) begin
            rt_ff <= (head_word.op == OP_RETRAIN);
         end else if (start_sweep && state_ff != ST_RT_DEQ) begin
            rt_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      // take a new word
      if (pop) begin
         mode_ff   <= head_word.op;
         status_ff <= head_word.status;
         label_ff  <= head_word.label;
         pick_ff   <= '0;
         rt_n_ff   <= cnt_ff;
         rt_k_ff   <= '0;
         rt_idx_ff <= rt_idx_first;
         j_ff      <= '0;
         for (int j = 0; j < NUM_FEATURES; j++) begin
            feat_ff[j] <= head_word.feature[j];
         end
         for (int c = 0; c < NUM_CLASSES; c++) begin
            score_ff[c] <= '0;
         end
      end
      // switch to the closing binarize of a retrain
      if (start_sweep && (state_ff == ST_SWEEP || state_ff == ST_RT_CLEAR)) begin
         mode_ff <= OP_BINARIZE;
      end
      // advance to the next ring sample
      if (sweep_last && rt_ff && mode_ff == OP_TRAIN) begin
         rt_k_ff   <= rt_k_ff + CNT_W'(1);
         rt_idx_ff <= (rt_idx_ff == RA_W'(RING_DEPTH - 1)) ? '0 : rt_idx_ff + RA_W'(1);
         j_ff      <= '0;
      end
      // dequantize one feature a cycle
      if (state_ff == ST_RT_DEQ) begin
         feat_ff[j_ff] <= dequantize(ring_rd_ff[j_ff*BYTE_W +: BYTE_W]);
         j_ff          <= j_ff + J_W'(1);
         if (deq_last) begin
            mode_ff  <= OP_TRAIN;
            label_ff <= ring_rd_ff[RING_W-1 -: LABEL_W];
         end
      end
      // accumulate scores
      if (v2_ff && mode_ff == OP_PREDICT) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            score_ff[c] <= hv ? score_ff[c] + ACC_W'($signed(cls2_ff[c]))
                              : score_ff[c] - ACC_W'($signed(cls2_ff[c]));
         end
      end
      // pick the best class, lower index wins ties
      if (state_ff == ST_PICK) begin
         if (pick_ff == '0 || score_ff[pick_ff] > best_ff) begin
            best_ff <= score_ff[pick_ff];
            cls_ff  <= LABEL_W'(pick_ff);
         end
         pick_ff <= pick_ff + C_W'(1);
      end
   end

   // saturate the score
   always_comb begin
      best_ext = CMP_W'(best_ff);
      if (best_ext > SCORE_MAX) begin
         best_sat = SCORE_MAX;
      end else if (best_ext < SCORE_MIN) begin
         best_sat = SCORE_MIN;
      end else begin
         best_sat = best_ext;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_cls_ff     <= (mode_ff == OP_PREDICT) ? cls_ff : '0;
         rsp_best_ff    <= (mode_ff == OP_PREDICT) ? best_sat[SCORE_W-1:0] : '0;
         rsp_status_ff  <= status_ff;
         rsp_stored_ff  <= STORED_W'(cnt_ff);
         rsp_trained_ff <= trained_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_class_index    = rsp_cls_ff;
   assign rsp_best_score     = rsp_best_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_samples_stored = rsp_stored_ff;
   assign rsp_trained_total  = rsp_trained_ff;

endmodule

// ===== design/hdc_projection_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdc_projection_classifier_unit
// Hyperdimensional classifier with a random projection, front decode and queue
// feeding a dimension-serial back end.
// ----------------------------------------------------------------------------
// Operation: after reset the class sums are cleared in a pass over the DIM
// rows, during which req_stall is high. A load or an unknown/refused word
// runs no sweep. Train, binarize and predict sweep one dimension a cycle
// through the class sum memory port, and predict then picks the best class.
// Retrain clears the sums, then reads, dequantizes and trains on each stored
// sample, and ends with a binarize. Two words can queue ahead of the back end,
// and a result in the output register holds up the back only once the next is done.
module hdc_projection_classifier_unit #(
   parameter int DIM          = 1024,
   parameter int NUM_FEATURES = 5,
   parameter int NUM_CLASSES  = 4,
   parameter int RING_DEPTH   = 64,
   parameter int SUM_WIDTH    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hdcpc_pkg::CMD_W-1:0]         req_cmd,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_0,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_1,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_2,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_3,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_feature_4,
   input  logic [hdcpc_pkg::LABEL_W-1:0]       req_label,
   input  logic [hdcpc_pkg::ROW_W-1:0]         req_proj_row,
   input  logic [hdcpc_pkg::COL_W-1:0]         req_proj_col,
   input  logic signed [hdcpc_pkg::FEAT_W-1:0] req_proj_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hdcpc_pkg::LABEL_W-1:0]       rsp_class_index,
   output logic signed [hdcpc_pkg::SCORE_W-1:0] rsp_best_score,
   output logic [hdcpc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [hdcpc_pkg::STORED_W-1:0]      rsp_samples_stored,
   output logic [hdcpc_pkg::TRAINED_W-1:0]     rsp_trained_total
);
   import hdcpc_pkg::*;

   cmd_word_type    head_word;
   logic            head_valid;
   back_status_type back_status;

   // decode and queue
   hdcpc_front #(
      .DIM          (DIM),
      .NUM_FEATURES (NUM_FEATURES),
      .NUM_CLASSES  (NUM_CLASSES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_feature_0  (req_feature_0),
      .req_feature_1  (req_feature_1),
      .req_feature_2  (req_feature_2),
      .req_feature_3  (req_feature_3),
      .req_feature_4  (req_feature_4),
      .req_label      (req_label),
      .req_proj_row   (req_proj_row),
      .req_proj_col   (req_proj_col),
      .req_proj_value (req_proj_value),
      .back_status    (back_status),
      .head_word      (head_word),
      .head_valid     (head_valid)
   );

   // execute
   hdcpc_back #(
      .DIM          (DIM),
      .NUM_FEATURES (NUM_FEATURES),
      .NUM_CLASSES  (NUM_CLASSES),
      .RING_DEPTH   (RING_DEPTH),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_word          (head_word),
      .head_valid         (head_valid),
      .back_status        (back_status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_class_index    (rsp_class_index),
      .rsp_best_score     (rsp_best_score),
      .rsp_status         (rsp_status),
      .rsp_samples_stored (rsp_samples_stored),
      .rsp_trained_total  (rsp_trained_total)
   );

`ifndef SYNTHESIS
   // no word enters during the clearing pass after reset
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> req_stall)
      else $error("word accepted during clearing pass");

   // the back only pops a queued word
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> head_valid)
      else $error("pop from empty queue");

   // refused words carry no prediction
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_best_score == '0 && rsp_class_index == '0))
      else $error("error response with prediction data");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the projection classifier. The bench first writes
// the whole projection table. It then runs directed words (extreme features,
// refused labels and indexes, unknown commands, an empty-ring retrain) and
// after that a long random mix of commands. Both channels idle at random.
// Every response word is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
   import hdcpc_pkg::*;

   localparam int DIM        = 1024;
   localparam int NFEAT      = 5;
   localparam int NCLASS     = 4;
   localparam int RING       = 64;
   localparam int SUM_LIM    = 32767;
   localparam int QONE       = 8192;
   localparam int STALL_LIMIT = 300000;

   typedef struct {
      logic [CMD_W-1:0]         cmd;
      logic signed [FEAT_W-1:0] feat [NFEAT];
      logic [LABEL_W-1:0]       label;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic signed [FEAT_W-1:0] value;
   } req_word_t;

   typedef struct packed {
      logic [LABEL_W-1:0]         cls;
      logic signed [SCORE_W-1:0]  score;
      logic [STATUS_W-1:0]        status;
      logic [STORED_W-1:0]        stored;
      logic [TRAINED_W-1:0]       trained;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CMD_W-1:0] req_cmd = '0;
   logic signed [FEAT_W-1:0] req_feature_0 = '0, req_feature_1 = '0, req_feature_2 = '0;
   logic signed [FEAT_W-1:0] req_feature_3 = '0, req_feature_4 = '0;
   logic [LABEL_W-1:0] req_label = '0;
   logic [ROW_W-1:0] req_proj_row = '0;
   logic [COL_W-1:0] req_proj_col = '0;
   logic signed [FEAT_W-1:0] req_proj_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [LABEL_W-1:0] rsp_class_index;
   logic signed [SCORE_W-1:0] rsp_best_score;
   logic [STATUS_W-1:0] rsp_status;
   logic [STORED_W-1:0] rsp_samples_stored;
   logic [TRAINED_W-1:0] rsp_trained_total;

   hdc_projection_classifier_unit u_top (.*);

   // model state
   shortint   proj_tbl [DIM][NFEAT];
   int        class_sum [NCLASS][DIM];
   byte unsigned ring_feat [RING][NFEAT];
   logic [LABEL_W-1:0] ring_lbl [RING];
   int        ring_head, ring_count, trained_cnt;
   bit        hv_neg [DIM];

   req_word_t pending_words [$];
   rsp_word_t expected_rsp [$];
   int sent_n = 0, acc_n = 0, req_gap = 0, rsp_gap = 0;
   int errors = 0, idle_cycles = 0, cyc = 0;
   int n_train = 0, n_predict = 0, n_retrain = 0, n_rsp = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // sign of each projection dot, zero counting as positive
   task automatic encode_hv(input int x [NFEAT]);
      longint dot;
      for (int i = 0; i < DIM; i++) begin
         dot = 0;
         for (int j = 0; j < NFEAT; j++) dot += longint'(proj_tbl[i][j]) * x[j];
         hv_neg[i] = (dot < 0);
      end
   endtask

   task automatic add_to_class(input int c);
      int s;
      for (int i = 0; i < DIM; i++) begin
         s = class_sum[c][i] + (hv_neg[i] ? -1 : 1);
         if (s > SUM_LIM) s = SUM_LIM;
         if (s < -SUM_LIM) s = -SUM_LIM;
         class_sum[c][i] = s;
      end
      if (trained_cnt < 65535) trained_cnt++;
   endtask

   task automatic binarize_sums();
      for (int c = 0; c < NCLASS; c++)
         for (int i = 0; i < DIM; i++) class_sum[c][i] = (class_sum[c][i] >= 0) ? 1 : -1;
   endtask

   // advance the classifier model by one word and return its response
   task automatic classify_word(input req_word_t w, output rsp_word_t r);
      int x [NFEAT];
      int idx, cc;
      longint s, best;
      r = '0;
      best = 0;
      for (int j = 0; j < NFEAT; j++) x[j] = int'(w.feat[j]);
      case (w.cmd)
         CMD_LOAD: begin
            if (w.col >= NFEAT) r.status = STAT_BAD_INDEX;
            else proj_tbl[w.row][w.col] = w.value;
         end
         CMD_TRAIN: begin
            if (w.label >= NCLASS) r.status = STAT_BAD_LABEL;
            else begin
               n_train++;
               encode_hv(x);
               add_to_class(w.label);
               for (int j = 0; j < NFEAT; j++) begin
                  cc = x[j];
                  if (cc < -QONE) cc = -QONE;
                  if (cc > QONE) cc = QONE;
                  ring_feat[ring_head][j] = 8'(((cc + QONE) * 255) / 16384);
               end
               ring_lbl[ring_head] = w.label;
               ring_head = (ring_head + 1) % RING;
               if (ring_count < RING) ring_count++;
            end
         end
         CMD_PREDICT: begin
            n_predict++;
            encode_hv(x);
            for (int c = 0; c < NCLASS; c++) begin
               s = 0;
               for (int i = 0; i < DIM; i++)
                  s += hv_neg[i] ? -class_sum[c][i] : class_sum[c][i];
               if (c == 0 || s > best) begin
                  best = s;
                  r.cls = LABEL_W'(c);
               end
            end
            if (best > 33554431) best = 33554431;
            if (best < -33554432) best = -33554432;
         end
         CMD_BINARIZE: binarize_sums();
         CMD_RETRAIN: begin
            n_retrain++;
            for (int c = 0; c < NCLASS; c++)
               for (int i = 0; i < DIM; i++) class_sum[c][i] = 0;
            idx = (ring_head + RING - ring_count) % RING;
            for (int k = 0; k < ring_count; k++) begin
               for (int j = 0; j < NFEAT; j++)
                  x[j] = (int'(ring_feat[idx][j]) * 16384 + 127) / 255 - QONE;
               encode_hv(x);
               add_to_class(ring_lbl[idx]);
               idx = (idx + 1) % RING;
            end
            binarize_sums();
         end
         default: ;
      endcase
      r.score = best[SCORE_W-1:0];
      r.stored = STORED_W'(ring_count);
      r.trained = TRAINED_W'(trained_cnt);
   endtask

   function automatic int pick_gap(input bit calm);
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   function automatic req_word_t make_word(input logic [CMD_W-1:0] cmd);
      req_word_t w;
      w.cmd = cmd;
      for (int j = 0; j < NFEAT; j++) begin
         case ($urandom_range(0, 5))
            0: w.feat[j] = 16'sh8000;
            1: w.feat[j] = 16'sh7FFF;
            2: w.feat[j] = 16'(int'($urandom_range(0, 16384)) - QONE);
            default: w.feat[j] = 16'($urandom);
         endcase
      end
      w.label = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom_range(0, 15))
                                             : LABEL_W'($urandom_range(0, 3));
      w.row = ROW_W'($urandom);
      w.col = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(0, 7))
                                           : COL_W'($urandom_range(0, 4));
      w.value = 16'($urandom);
      return w;
   endfunction

   // drive request words on the falling edge
   always @(negedge clock) begin
      cyc <= cyc + 1;
      if (!reset) begin
         if (!(req_valid && sent_n != acc_n)) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_word_t w;
               w = pending_words.pop_front();
               req_cmd <= w.cmd;
               req_feature_0 <= w.feat[0];
               req_feature_1 <= w.feat[1];
               req_feature_2 <= w.feat[2];
               req_feature_3 <= w.feat[3];
               req_feature_4 <= w.feat[4];
               req_label <= w.label;
               req_proj_row <= w.row;
               req_proj_col <= w.col;
               req_proj_value <= w.value;
               req_valid <= 1'b1;
               sent_n <= sent_n + 1;
               req_gap <= pick_gap((cyc / 4000) % 4 == 0);
            end else begin
               req_valid <= 1'b0;
            end
         end
         // stall the response side in bursts
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_gap <= pick_gap((cyc / 4000) % 4 == 1);
         end
      end
   end

   // accept request words, check response words, watch for a hang
   always @(posedge clock) begin
      req_word_t w;
      rsp_word_t r, got;
      bit busy;
      busy = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         w.cmd = req_cmd;
         w.feat[0] = req_feature_0;
         w.feat[1] = req_feature_1;
         w.feat[2] = req_feature_2;
         w.feat[3] = req_feature_3;
         w.feat[4] = req_feature_4;
         w.label = req_label;
         w.row = req_proj_row;
         w.col = req_proj_col;
         w.value = req_proj_value;
         classify_word(w, r);
         expected_rsp.push_back(r);
         acc_n <= acc_n + 1;
         busy = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         busy = 1'b1;
         n_rsp++;
         got = {rsp_class_index, rsp_best_score, rsp_status, rsp_samples_stored,
                rsp_trained_total};
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response word with none expected: %p", $time, got);
         end else begin
            r = expected_rsp.pop_front();
            if (got.cls !== r.cls || got.score !== r.score || got.status !== r.status ||
                got.stored !== r.stored || got.trained !== r.trained) begin
               errors++;
               $display("%0t: mismatch expected %p actual %p", $time, r, got);
            end
         end
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_word_t w;
      // write every projection entry, with extremes and zeros sprinkled in
      for (int i = 0; i < DIM; i++)
         for (int j = 0; j < NFEAT; j++) begin
            w = make_word(CMD_LOAD);
            w.row = ROW_W'(i);
            w.col = COL_W'(j);
            if (i < 4) w.value = (i == 0) ? 16'sh8000 : (i == 1) ? 16'sh7FFF : 16'sh0;
            pending_words.push_back(w);
         end
      // directed words
      pending_words.push_back(make_word(CMD_RETRAIN));
      pending_words.push_back(make_word(CMD_PREDICT));
      for (int k = 0; k < 6; k++) begin
         w = make_word(CMD_TRAIN);
         w.label = LABEL_W'(k % NCLASS);
         for (int j = 0; j < NFEAT; j++)
            w.feat[j] = (k == 0) ? 16'sh8000 : (k == 1) ? 16'sh7FFF : (k == 2) ? 16'sh0 : w.feat[j];
         pending_words.push_back(w);
      end
      w = make_word(CMD_TRAIN); w.label = LABEL_W'(NCLASS); pending_words.push_back(w);
      w = make_word(CMD_TRAIN); w.label = 4'd15; pending_words.push_back(w);
      w = make_word(CMD_LOAD); w.col = 3'd5; pending_words.push_back(w);
      w = make_word(CMD_LOAD); w.col = 3'd7; pending_words.push_back(w);
      w = make_word(CMD_PREDICT);
      for (int j = 0; j < NFEAT; j++) w.feat[j] = '0;
      pending_words.push_back(w);
      pending_words.push_back(make_word(CMD_PREDICT));
      pending_words.push_back(make_word(CMD_BINARIZE));
      pending_words.push_back(make_word(CMD_PREDICT));
      for (int k = 5; k < 8; k++) pending_words.push_back(make_word(CMD_W'(k)));
      pending_words.push_back(make_word(CMD_RETRAIN));
      pending_words.push_back(make_word(CMD_PREDICT));
      // random mix; retrain kept rare since it replays the whole ring
      for (int k = 0; k < 1400; k++) begin
         int p;
         p = $urandom_range(0, 999);
         if (p < 400) w = make_word(CMD_LOAD);
         else if (p < 680) w = make_word(CMD_TRAIN);
         else if (p < 940) w = make_word(CMD_PREDICT);
         else if (p < 970) w = make_word(CMD_BINARIZE);
         else if (p < 975) w = make_word(CMD_RETRAIN);
         else w = make_word(CMD_W'($urandom_range(5, 7)));
         pending_words.push_back(w);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // drain then let the pipeline settle
      do begin
         @(posedge clock);
      end while (!(pending_words.size() == 0 && !req_valid && sent_n == acc_n &&
                   expected_rsp.size() == 0));
      repeat (50) @(posedge clock);
      if (expected_rsp.size() != 0) errors++;
      $display("covered %0d requests, %0d responses: %0d trains, %0d predicts, %0d retrains",
               acc_n, n_rsp, n_train, n_predict, n_retrain);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/hdcpc_pkg.sv
design/hdcpc_front.sv
design/hdcpc_back.sv
design/hdc_projection_classifier_unit.sv
test/testbench.sv
